// File: rtl/tbr_pkg.sv
`default_nettype none
package tbr_pkg;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_RD   = 3'd1;
  localparam logic [2:0] OP_WR   = 3'd2;
  localparam logic [2:0] OP_MEM  = 3'd3;
  localparam logic [2:0] OP_ACK  = 3'd4;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [2:0] PF_NONE = 3'd0;
  localparam logic [2:0] PF_TILE = 3'd1;
  localparam logic [2:0] PF_ATTR = 3'd2;
  localparam logic [2:0] PF_PLO  = 3'd3;
  localparam logic [2:0] PF_PHI  = 3'd4;
  localparam logic [2:0] PF_DATA = 3'd5;

  localparam logic [1:0] MOP_NONE = 2'd0;
  localparam logic [1:0] MOP_RD   = 2'd1;
  localparam logic [1:0] MOP_WR   = 2'd2;

  localparam logic [8:0] PRE_LINE  = 9'd261;
  localparam logic [8:0] LAST_LINE = 9'd260;
  localparam logic [8:0] LAST_DOT  = 9'd340;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] mem_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  reg_read_data;
    logic        pixel_valid;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [23:0] pixel_rgb;
    logic [1:0]  mem_op;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic        nmi_level;
    logic        frame_done;
  } rsp_t;

  // Front to back: response minus the colour, plus the colour index to look up.
  typedef struct packed {
    rsp_t       rsp;
    logic       colour_en;
    logic [5:0] colour_idx;
  } mid_t;

  function automatic logic [23:0] colour_lut(input logic [5:0] idx);
    logic [23:0] c;
    case (idx)
      6'd0: c = 24'h626262; 6'd1: c = 24'h001C95; 6'd2: c = 24'h1904AC; 6'd3: c = 24'h42009D;
      6'd4: c = 24'h61006B; 6'd5: c = 24'h6E0025; 6'd6: c = 24'h650500; 6'd7: c = 24'h491E00;
      6'd8: c = 24'h223700; 6'd9: c = 24'h004900; 6'd10: c = 24'h004F00; 6'd11: c = 24'h004816;
      6'd12: c = 24'h00355E;
      6'd16: c = 24'hABABAB; 6'd17: c = 24'h0C4EDB; 6'd18: c = 24'h3D2EFF; 6'd19: c = 24'h7115F3;
      6'd20: c = 24'h9B0BB9; 6'd21: c = 24'hB01262; 6'd22: c = 24'hA92704; 6'd23: c = 24'h894600;
      6'd24: c = 24'h576600; 6'd25: c = 24'h237F00; 6'd26: c = 24'h008900; 6'd27: c = 24'h008332;
      6'd28: c = 24'h006D90;
      6'd32: c = 24'hFFFFFF; 6'd33: c = 24'h57A5FF; 6'd34: c = 24'h8287FF; 6'd35: c = 24'hB46DFF;
      6'd36: c = 24'hDF60FF; 6'd37: c = 24'hF863C6; 6'd38: c = 24'hF8746D; 6'd39: c = 24'hDE9020;
      6'd40: c = 24'hB3AE00; 6'd41: c = 24'h81C800; 6'd42: c = 24'h56D522; 6'd43: c = 24'h3DD36F;
      6'd44: c = 24'h3EC1C8; 6'd45: c = 24'h4E4E4E;
      6'd48: c = 24'hFFFFFF; 6'd49: c = 24'hBEE0FF; 6'd50: c = 24'hCDD4FF; 6'd51: c = 24'hE0CAFF;
      6'd52: c = 24'hF1C4FF; 6'd53: c = 24'hFCC4EF; 6'd54: c = 24'hFDCACE; 6'd55: c = 24'hF5D4AF;
      6'd56: c = 24'hE6DF9C; 6'd57: c = 24'hD3E99A; 6'd58: c = 24'hC2EFA8; 6'd59: c = 24'hB7EFC4;
      6'd60: c = 24'hB6EAE5; 6'd61: c = 24'hB8B8B8;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/tbr_front.sv
`default_nettype none
module tbr_front
  import tbr_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic en_i,
  input  wire  req_t req_i,
  output mid_t       mid_o
);

  logic [8:0]  line_q, line_d, dot_q, dot_d;
  logic [7:0]  ctrl_q, ctrl_d, mask_q, mask_d;
  logic        vbl_q, vbl_d, tog_q, tog_d, nmi_q, nmi_d;
  logic [15:0] v_q, v_d, t_q, t_d;
  logic [2:0]  fx_q, fx_d, pf_q, pf_d;
  logic [7:0]  rbuf_q, rbuf_d, tile_q, tile_d, plo_q, plo_d, phi_q, phi_d;
  logic [1:0]  attr_q, attr_d;
  logic [15:0] sh_q [4];
  logic [15:0] sh_d [4];
  logic [7:0]  pal_q [32];
  logic        pal_we;
  logic [4:0]  pal_wa;

  always_comb begin
    logic       draw, rend, fetch;
    logic [8:0] d;
    logic [4:0] cy;
    logic [7:0] mv;
    logic [3:0] b;
    logic [4:0] pidx;
    mid_t       m;
    line_d = line_q; dot_d = dot_q; ctrl_d = ctrl_q; mask_d = mask_q;
    vbl_d = vbl_q; tog_d = tog_q; nmi_d = nmi_q; v_d = v_q; t_d = t_q;
    fx_d = fx_q; pf_d = pf_q; rbuf_d = rbuf_q; tile_d = tile_q;
    plo_d = plo_q; phi_d = phi_q; attr_d = attr_q;
    for (int i = 0; i < 4; i++) sh_d[i] = sh_q[i];
    pal_we = 1'b0; pal_wa = v_q[4:0];
    m = '0;
    rend = mask_q[4] | mask_q[3];
    d = dot_q; cy = '0; mv = '0; b = '0; pidx = '0; draw = 1'b0; fetch = 1'b0;
    case (req_i.opcode)
      OP_TICK: begin
        draw = (line_q < 9'd240) || (line_q == PRE_LINE);
        if (line_q == 9'd0 && dot_q == 9'd0) d = 9'd1;
        if (line_q == PRE_LINE && d == 9'd1) vbl_d = 1'b0;
        fetch = draw && ((d >= 9'd2 && d <= 9'd257) || (d >= 9'd321 && d <= 9'd337));
        if (fetch) begin
          if (mask_q[3])
            for (int i = 0; i < 4; i++) sh_d[i] = {sh_q[i][14:0], 1'b0};
          case (3'(d - 9'd1))
            3'd0: begin
              sh_d[0][7:0] = plo_q; sh_d[1][7:0] = phi_q;
              sh_d[2][7:0] = {8{attr_q[0]}}; sh_d[3][7:0] = {8{attr_q[1]}};
              m.rsp.mem_op = MOP_RD; m.rsp.mem_address = {4'h2, v_q[11:0]}; pf_d = PF_TILE;
            end
            3'd2: begin
              m.rsp.mem_op = MOP_RD;
              m.rsp.mem_address = {4'h2, v_q[11:10], 4'hF, v_q[9:7], v_q[4:2]};
              pf_d = PF_ATTR;
            end
            3'd4: begin
              m.rsp.mem_op = MOP_RD;
              m.rsp.mem_address = {3'b000, ctrl_q[4], tile_q, 1'b0, v_q[14:12]};
              pf_d = PF_PLO;
            end
            3'd6: begin
              m.rsp.mem_op = MOP_RD;
              m.rsp.mem_address = {3'b000, ctrl_q[4], tile_q, 1'b1, v_q[14:12]};
              pf_d = PF_PHI;
            end
            3'd7: if (rend) begin
              if (v_q[4:0] == 5'd31) v_d = {v_q[15:11], ~v_q[10], v_q[9:5], 5'd0};
              else v_d = v_q + 16'd1;
            end
            default: ;
          endcase
          // dot 256 also took the coarse X step above; fine Y builds on it
          if (d == 9'd256 && rend) begin
            if (v_d[14:12] != 3'd7) v_d = v_d + 16'h1000;
            else begin
              cy = v_d[9:5];
              v_d = v_d & 16'h8FFF;
              if (cy == 5'd29) begin cy = '0; v_d[11] = ~v_d[11]; end
              else if (cy == 5'd31) cy = '0;
              else cy = cy + 5'd1;
              v_d[9:5] = cy;
            end
          end
          if (d == 9'd257) begin
            sh_d[0][7:0] = plo_q; sh_d[1][7:0] = phi_q;
            sh_d[2][7:0] = {8{attr_q[0]}}; sh_d[3][7:0] = {8{attr_q[1]}};
            if (rend) v_d = (v_q & ~16'h041F) | (t_q & 16'h041F);
          end
        end
        if (line_q == PRE_LINE && d >= 9'd280 && d <= 9'd304 && rend)
          v_d = (v_q & ~16'h7BE0) | (t_q & 16'h7BE0);
        if (line_q == 9'd241 && d == 9'd1) begin
          vbl_d = 1'b1;
          if (ctrl_q[7]) nmi_d = 1'b1;
        end
        // colour index from the post-shift shifter taps
        b = 4'd15 - {1'b0, fx_q};
        pidx = {sh_d[3][b], sh_d[2][b], sh_d[1][b], sh_d[0][b]};
        m.colour_en = 1'b1;
        m.colour_idx = mask_q[3] ? pal_q[pidx][5:0] : 6'd0;
        if (line_q < 9'd240 && d >= 9'd1 && d <= 9'd256) begin
          m.rsp.pixel_valid = 1'b1;
          m.rsp.pixel_x = 8'(d - 9'd1);
          m.rsp.pixel_y = line_q[7:0];
        end
        if (d >= LAST_DOT) begin
          dot_d = '0;
          if (line_q == PRE_LINE) line_d = '0;
          else if (line_q >= LAST_LINE) begin line_d = PRE_LINE; m.rsp.frame_done = 1'b1; end
          else line_d = line_q + 9'd1;
        end else dot_d = d + 9'd1;
      end
      OP_RD: begin
        if (req_i.reg_index == REG_STATUS) begin
          m.rsp.reg_read_data = {vbl_q, 7'd0}; tog_d = 1'b0; vbl_d = 1'b0;
        end else if (req_i.reg_index == REG_DATA) begin
          m.rsp.reg_read_data = rbuf_q;
          if (v_q[13:8] == 6'h3F) begin
            rbuf_d = pal_q[v_q[4:0]]; m.rsp.reg_read_data = pal_q[v_q[4:0]];
          end else begin
            m.rsp.mem_op = MOP_RD; m.rsp.mem_address = {2'b00, v_q[13:0]}; pf_d = PF_DATA;
          end
          v_d = v_q + (ctrl_q[2] ? 16'd32 : 16'd1);
        end
      end
      OP_WR: begin
        case (req_i.reg_index)
          REG_CTRL: begin ctrl_d = req_i.write_data; t_d[11:10] = req_i.write_data[1:0]; end
          REG_MASK: mask_d = req_i.write_data;
          REG_SCROLL: begin
            if (!tog_q) begin
              fx_d = req_i.write_data[2:0]; t_d[4:0] = req_i.write_data[7:3]; tog_d = 1'b1;
            end else begin
              t_d[14:12] = req_i.write_data[2:0]; t_d[9:5] = req_i.write_data[7:3];
              tog_d = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!tog_q) begin
              t_d = {2'b00, req_i.write_data[5:0], t_q[7:0]}; tog_d = 1'b1;
            end else begin
              t_d = {t_q[15:8], req_i.write_data}; v_d = {t_q[15:8], req_i.write_data};
              tog_d = 1'b0;
            end
          end
          REG_DATA: begin
            if (v_q[13:8] == 6'h3F) pal_we = 1'b1;
            else begin
              m.rsp.mem_op = MOP_WR; m.rsp.mem_address = {2'b00, v_q[13:0]};
              m.rsp.mem_write_data = req_i.write_data;
            end
            v_d = v_q + (ctrl_q[2] ? 16'd32 : 16'd1);
          end
          default: ;
        endcase
      end
      OP_MEM: begin
        mv = req_i.mem_data;
        if (v_q[6]) mv = mv >> 4;
        if (v_q[1]) mv = mv >> 2;
        case (pf_q)
          PF_TILE: tile_d = req_i.mem_data;
          PF_ATTR: attr_d = mv[1:0];
          PF_PLO:  plo_d = req_i.mem_data;
          PF_PHI:  phi_d = req_i.mem_data;
          PF_DATA: rbuf_d = req_i.mem_data;
          default: ;
        endcase
        pf_d = PF_NONE;
      end
      OP_ACK: nmi_d = 1'b0;
      default: ;
    endcase
    m.rsp.nmi_level = nmi_d;
    mid_o = m;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0; dot_q <= '0; ctrl_q <= '0; mask_q <= '0; vbl_q <= 1'b0;
      tog_q <= 1'b0; nmi_q <= 1'b0; v_q <= '0; t_q <= '0; fx_q <= '0; pf_q <= PF_NONE;
      rbuf_q <= '0; tile_q <= '0; plo_q <= '0; phi_q <= '0; attr_q <= '0;
      for (int i = 0; i < 4; i++) sh_q[i] <= '0;
    end else if (en_i) begin
      line_q <= line_d; dot_q <= dot_d; ctrl_q <= ctrl_d; mask_q <= mask_d; vbl_q <= vbl_d;
      tog_q <= tog_d; nmi_q <= nmi_d; v_q <= v_d; t_q <= t_d; fx_q <= fx_d; pf_q <= pf_d;
      rbuf_q <= rbuf_d; tile_q <= tile_d; plo_q <= plo_d; phi_q <= phi_d; attr_q <= attr_d;
      for (int i = 0; i < 4; i++) sh_q[i] <= sh_d[i];
    end
  end

  // palette: 32 bytes, one write port, read at fixed taps by index
  always_ff @(posedge clk_i) begin
    if (en_i && pal_we) pal_q[pal_wa] <= req_i.write_data;
  end

endmodule
`default_nettype wire

// File: rtl/tbr_back.sv
`default_nettype none
module tbr_back
  import tbr_pkg::*;
(
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       push_i,
  output logic             full_o,
  input  wire  mid_t       mid_i,
  output logic             empty_o,
  input  wire  logic       pop_i,
  output rsp_t             rsp_o
);

  // two-entry queue of finished responses
  rsp_t       q_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  rsp_t       r;

  always_comb begin
    r = mid_i.rsp;
    if (mid_i.colour_en) r.pixel_rgb = colour_lut(mid_i.colour_idx);
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rsp_o   = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) q_q[wp_q] <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

endmodule
`default_nettype wire

// File: rtl/tile_background_renderer.sv
`default_nettype none
// Channel   | Handshake     | Payload
// ----------+---------------+------------------------------
// request   | push_i/full_o | req_i   (opcode, reg, data)
// response  | pop_i/empty_o | rsp_o   (pixel, memory, regs)
//
// One request per cycle while full_o is low; its response is in the queue the next cycle.
// The front updates raster, scroll, fetch state and reads the palette;
// the back looks up the colour table and holds a two-entry response queue.
// full_o rises only when the queue holds two unread responses.
// Reset (rst_ni low, async) clears all control state; palette is undefined until written.
module tile_background_renderer
  import tbr_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic push_i,
  output logic       full_o,
  input  wire  req_t req_i,
  output logic       empty_o,
  input  wire  logic pop_i,
  output rsp_t       rsp_o
);

  mid_t       mid;
  logic       acc;

  assign acc = push_i && !full_o;

  tbr_front u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (acc),
    .req_i (req_i),
    .mid_o (mid)
  );

  tbr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .mid_i     (mid),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .rsp_o     (rsp_o)
  );

`ifndef ASSERT_OFF
  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni) !(full_o && empty_o))
    else $error("queue full and empty");
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !push_i) |=> !full_o) else $error("full after pop");
`endif

endmodule
`default_nettype wire
